// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define CVP_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold whenever the antecedent holds, same edge
`define CVP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/cvp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvp_pkg
// widths, fixed-point constants and the arctangent table of the polar converter
// ----------------------------------------------------------------------------
package cvp_pkg;

	localparam int ITERATIONS  = 15;
	localparam int FRAC_BITS   = 16;
	localparam int INPUT_WIDTH = 16;

	localparam int IDX_W   = 4;
	localparam int XW      = INPUT_WIDTH + FRAC_BITS + 3;
	localparam int TW      = FRAC_BITS + 5;
	localparam int MAG_W   = 32;
	localparam int ANGLE_W = 19;
	localparam int SUM_W   = (XW + 1 > MAG_W + 1) ? XW + 1 : MAG_W + 1;

	localparam int IN_TDATA_W  = ((2 * INPUT_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((MAG_W + ANGLE_W + 7) / 8) * 8;

	typedef logic signed [TW-1:0] theta_t;
	typedef logic signed [XW-1:0] xy_t;

	// one vector on its way through the rotation chain
	typedef struct packed {
		logic   origin;
		xy_t    x;
		xy_t    y;
		theta_t theta;
	} vec_t;

	// round a 30-fraction-bit constant to FRAC_BITS
	function automatic longint q30_to_frac(input longint c);
		return (c + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
	endfunction

	localparam longint NINETY   = q30_to_frac(64'd1686633657);
	localparam longint CIRCLE   = q30_to_frac(64'd6746523891);
	localparam longint SCALE    = q30_to_frac(64'd652137097);
	localparam longint ANGLE_TOP = (longint'(1) << ANGLE_W) - 1;
	localparam longint ANGLE_LIM = (CIRCLE - 1 > ANGLE_TOP) ? ANGLE_TOP : CIRCLE - 1;

	localparam theta_t TH_Q2 = theta_t'(NINETY);
	localparam theta_t TH_Q3 = theta_t'(2 * NINETY);
	localparam theta_t TH_Q4 = theta_t'(CIRCLE - NINETY);
	localparam theta_t TH_LIM = theta_t'(ANGLE_LIM);

	localparam logic [FRAC_BITS-1:0] SCALE_K = FRAC_BITS'(SCALE);
	localparam logic [MAG_W-1:0]     MAG_ALL = '1;

	// atan(2^-i) in radians, FRAC_BITS fraction bits
	function automatic theta_t atan_lut(input logic [IDX_W-1:0] i);
		logic [31:0] a;
		case (i)
			4'd0:    a = 32'd843314856;
			4'd1:    a = 32'd497837829;
			4'd2:    a = 32'd263043836;
			4'd3:    a = 32'd133525158;
			4'd4:    a = 32'd67021686;
			4'd5:    a = 32'd33543515;
			4'd6:    a = 32'd16775850;
			4'd7:    a = 32'd8388437;
			4'd8:    a = 32'd4194282;
			4'd9:    a = 32'd2097149;
			4'd10:   a = 32'd1048575;
			4'd11:   a = 32'd524287;
			4'd12:   a = 32'd262143;
			4'd13:   a = 32'd131071;
			4'd14:   a = 32'd65535;
			default: a = 32'd32767;
		endcase
		return theta_t'(q30_to_frac(longint'(a)));
	endfunction

endpackage

// File: rtl/cvp_prerot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvp_prerot
// input stage: scales the sample to fixed point and folds it into quadrant 1
// ----------------------------------------------------------------------------
module cvp_prerot import cvp_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [INPUT_WIDTH-1:0] x_in,
	input  logic signed [INPUT_WIDTH-1:0] y_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output vec_t                          out_data
);

	xy_t  xs, ys;
	vec_t nxt;
	logic vld_s1;
	vec_t data_s1;

	always_comb begin
		xs = {{(XW - INPUT_WIDTH - FRAC_BITS){x_in[INPUT_WIDTH-1]}}, x_in, {FRAC_BITS{1'b0}}};
		ys = {{(XW - INPUT_WIDTH - FRAC_BITS){y_in[INPUT_WIDTH-1]}}, y_in, {FRAC_BITS{1'b0}}};
		nxt.origin = (x_in == '0) && (y_in == '0);
		nxt.x      = xs;
		nxt.y      = ys;
		nxt.theta  = '0;
		if (x_in <= 0 && y_in > 0) begin
			// quadrant 2: rotate clockwise by 90 degrees
			nxt.x     = ys;
			nxt.y     = -xs;
			nxt.theta = TH_Q2;
		end else if (x_in < 0 && y_in <= 0) begin
			// quadrant 3: point reflection
			nxt.x     = -xs;
			nxt.y     = -ys;
			nxt.theta = TH_Q3;
		end else if (x_in >= 0 && y_in < 0) begin
			// quadrant 4: rotate counterclockwise by 90 degrees
			nxt.x     = -ys;
			nxt.y     = xs;
			nxt.theta = TH_Q4;
		end
	end

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

// File: rtl/cvp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvp_cell
// one vectoring micro-rotation with its own pipeline register
// ----------------------------------------------------------------------------
module cvp_cell import cvp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  theta_t           atan,
	input  logic             in_valid,
	output logic             in_ready,
	input  vec_t             in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output vec_t             out_data
);

	xy_t    xc, yc, sx, sy;
	theta_t tc;
	vec_t   nxt;
	logic   vld_s1;
	vec_t   data_s1;

	always_comb begin
		xc = in_data.x;
		yc = in_data.y;
		tc = in_data.theta;
		sx = xc >>> idx;
		sy = yc >>> idx;
		nxt.origin = in_data.origin;
		// steer by the sign of y, zero counts as not positive
		if (yc > 0) begin
			nxt.x     = xc + sy;
			nxt.y     = yc - sx;
			nxt.theta = tc + atan;
		end else begin
			nxt.x     = xc - sy;
			nxt.y     = yc + sx;
			nxt.theta = tc - atan;
		end
	end

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

// File: rtl/cvp_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvp_scale
// gain correction of the magnitude and clamping of the angle, two stages
// ----------------------------------------------------------------------------
module cvp_scale import cvp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  vec_t               in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [MAG_W-1:0]   magnitude,
	output logic [ANGLE_W-1:0] angle
);

	xy_t                    xc;
	theta_t                 tc;
	logic [XW-FRAC_BITS-1:0] hi;
	logic [FRAC_BITS-1:0]   lo;
	logic [XW-1:0]          prod_hi;
	logic [2*FRAC_BITS-1:0] prod_lo;
	logic [ANGLE_W-1:0]     ang_nxt;
	logic [SUM_W-1:0]       sum;
	logic                   rdy_s2;

	logic                   vld_s1, pos_s1;
	logic [XW-1:0]          prod_hi_s1;
	logic [2*FRAC_BITS-1:0] prod_lo_s1;
	logic [ANGLE_W-1:0]     angle_s1;

	logic                   vld_s2;
	logic [MAG_W-1:0]       mag_s2;
	logic [ANGLE_W-1:0]     angle_s2;

	always_comb begin
		xc = in_data.x;
		tc = in_data.theta;
		hi = xc[XW-1:FRAC_BITS];
		lo = xc[FRAC_BITS-1:0];
		prod_hi = XW'(hi) * XW'(SCALE_K);
		prod_lo = (2*FRAC_BITS)'(lo) * (2*FRAC_BITS)'(SCALE_K);
		if (in_data.origin || tc < 0) begin
			ang_nxt = '0;
		end else if (tc > TH_LIM) begin
			ang_nxt = ANGLE_W'(TH_LIM);
		end else begin
			ang_nxt = ANGLE_W'(tc);
		end
	end

	assign sum = SUM_W'(prod_hi_s1) + SUM_W'(prod_lo_s1 >> FRAC_BITS);

	assign rdy_s2   = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pos_s1     <= xc > 0;
			prod_hi_s1 <= prod_hi;
			prod_lo_s1 <= prod_lo;
			angle_s1   <= ang_nxt;
		end
		if (rdy_s2 && vld_s1) begin
			angle_s2 <= angle_s1;
			if (!pos_s1) begin
				mag_s2 <= '0;
			end else if (sum > SUM_W'(MAG_ALL)) begin
				mag_s2 <= MAG_ALL;
			end else begin
				mag_s2 <= sum[MAG_W-1:0];
			end
		end
	end

	assign out_valid = vld_s2;
	assign magnitude = mag_s2;
	assign angle     = angle_s2;

endmodule

// File: rtl/cordic_vectoring_polar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_vectoring_polar
// rectangular to polar conversion of signed samples by cordic vectoring
// ----------------------------------------------------------------------------
// usage
//   input stream: one transfer per sample, x and y as signed 16-bit integers
//   output stream: one transfer per sample, magnitude and angle, both
//     unsigned with 16 fraction bits, angle in radians from 0 to below 2 pi
//   pipeline: 1 quadrant fold stage, 15 rotation cells and 2 gain
//     correction stages
//   throughput: one sample per cycle while m_axis_tready stays high; each
//     rotation cell holds one sample and hands it on when its successor takes it
//   the origin gives zero magnitude and zero angle
//   reset: all stage valid flags clear, the pipeline comes up empty and
//     s_axis_tready is high at the first edge after reset
//   stall: every stage advances when it is empty or its successor takes
//     its data, so bubbles collapse while m_axis_tready is low and inputs
//     keep being accepted until all 18 stages hold a sample
// ----------------------------------------------------------------------------
module cordic_vectoring_polar import cvp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // x_in [15:0], y_in [31:16]
	// output stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // magnitude [31:0], angle [50:32], zero pad
);

`include "assert_macros.svh"

	// chain of vectors between the fold stage, the cells and the gain stage
	vec_t chain_data [0:ITERATIONS];
	logic chain_vld  [0:ITERATIONS];
	logic chain_rdy  [0:ITERATIONS];

	logic [MAG_W-1:0]   magnitude;
	logic [ANGLE_W-1:0] angle;

	// quadrant fold and scaling to fixed point
	cvp_prerot u_prerot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.x_in      (s_axis_tdata[INPUT_WIDTH-1:0]),
		.y_in      (s_axis_tdata[2*INPUT_WIDTH-1:INPUT_WIDTH]),
		.out_valid (chain_vld[0]),
		.out_ready (chain_rdy[0]),
		.out_data  (chain_data[0])
	);

	// one cell per micro-rotation, shift and arctangent fixed by position
	for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
		cvp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (IDX_W'(k)),
			.atan      (atan_lut(IDX_W'(k))),
			.in_valid  (chain_vld[k]),
			.in_ready  (chain_rdy[k]),
			.in_data   (chain_data[k]),
			.out_valid (chain_vld[k+1]),
			.out_ready (chain_rdy[k+1]),
			.out_data  (chain_data[k+1])
		);
	end

	// gain correction, angle clamp and output register
	cvp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_vld[ITERATIONS]),
		.in_ready  (chain_rdy[ITERATIONS]),
		.in_data   (chain_data[ITERATIONS]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.magnitude (magnitude),
		.angle     (angle)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - MAG_W - ANGLE_W){1'b0}}, angle, magnitude};

	// input back-pressure only comes from a full pipeline behind a waiting result
	`CVP_ASSERT_IMPL(a_stall_only_when_full, !s_axis_tready, m_axis_tvalid, "input stalled with no result waiting")

	// the origin enters the cells as an all-zero vector
	`CVP_ASSERT_IMPL(a_origin_folded, chain_vld[0] && chain_data[0].origin, chain_data[0].x == '0 && chain_data[0].y == '0, "origin not zero after fold")

	// and the cells keep x at zero for it
	`CVP_ASSERT_IMPL(a_origin_kept, chain_vld[ITERATIONS] && chain_data[ITERATIONS].origin, chain_data[ITERATIONS].x == '0, "origin x changed in rotation cells")

endmodule

// File: dv/tb_cordic_vectoring_polar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cordic_vectoring_polar
// self-checking bench for the cordic rectangular to polar converter
// ----------------------------------------------------------------------------
// every accepted (x, y) sample is run through a bit-true polar model in the
// bench and the expected magnitude and angle are queued; the output process
// compares each output transfer with the oldest entry. both streams stall at
// random except in one burst test that runs at full rate on both sides.
// ----------------------------------------------------------------------------
module tb_cordic_vectoring_polar;
	import cvp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PRINT_LIMIT    = 40;

	// expected output of one sample
	typedef struct packed {
		logic [31:0] magnitude;
		logic [18:0] angle;
	} polar_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // x_in [15:0], y_in [31:16]
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // magnitude [31:0], angle [50:32]

	polar_t expected_polar[$];
	int     mismatch_count;
	int     quiet_cycles;
	bit     gaps_on;

	cordic_vectoring_polar dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------------
	// polar model
	// ------------------------------------------------------------------------

	// 30-fraction-bit constant rounded to nearest at the output precision
	function automatic longint frac_round(input longint c30);
		longint unit;
		unit = longint'(1) << (30 - FRAC_BITS);
		return (c30 + unit / 2) / unit;
	endfunction

	localparam longint QUARTER_TURN = frac_round(64'd1686633657);
	localparam longint FULL_TURN    = frac_round(64'd6746523891);
	localparam longint GAIN_FIX     = frac_round(64'd652137097);
	localparam longint MAG_CEIL     = 64'hFFFF_FFFF;
	localparam longint ANGLE_CEIL   = (FULL_TURN - 1 > 64'h7FFFF) ? 64'h7FFFF : FULL_TURN - 1;

	// atan(2^-i), 30 fraction bits
	longint atan_q30[16] = '{
		843314856, 497837829, 263043836, 133525158,
		67021686,  33543515,  16775850,  8388437,
		4194282,   2097149,   1048575,   524287,
		262143,    131071,    65535,     32767
	};

	function automatic polar_t polar_of(input logic signed [15:0] xi,
			input logic signed [15:0] yi);
		longint x, y, t, theta, sx, sy, hi, lo, mag;
		polar_t r;
		x = xi;
		y = yi;
		theta = 0;
		r = '0;
		if (x == 0 && y == 0)
			return r;
		x = x * (longint'(1) << FRAC_BITS);
		y = y * (longint'(1) << FRAC_BITS);
		// fold quadrants 2, 3 and 4 onto quadrant 1 and seed the angle
		if (x <= 0 && y > 0) begin
			t = x; x = y; y = -t;
			theta = QUARTER_TURN;
		end else if (x < 0 && y <= 0) begin
			x = -x; y = -y;
			theta = 2 * QUARTER_TURN;
		end else if (x >= 0 && y < 0) begin
			t = x; x = -y; y = t;
			theta = FULL_TURN - QUARTER_TURN;
		end
		// micro-rotations, y of zero counts as rotate counterclockwise
		for (int i = 0; i < ITERATIONS && i < 16; i++) begin
			sx = x >>> i;
			sy = y >>> i;
			if (y > 0) begin
				x = x + sy; y = y - sx; theta = theta + frac_round(atan_q30[i]);
			end else begin
				x = x - sy; y = y + sx; theta = theta - frac_round(atan_q30[i]);
			end
		end
		// gain correction, integer and fraction parts scaled apart
		if (x <= 0) begin
			mag = 0;
		end else begin
			hi = x >>> FRAC_BITS;
			lo = x & ((longint'(1) << FRAC_BITS) - 1);
			mag = (hi > MAG_CEIL) ? MAG_CEIL : hi * GAIN_FIX + ((lo * GAIN_FIX) >>> FRAC_BITS);
			if (mag > MAG_CEIL)
				mag = MAG_CEIL;
		end
		if (theta < 0)
			theta = 0;
		if (theta > ANGLE_CEIL)
			theta = ANGLE_CEIL;
		r.magnitude = mag[31:0];
		r.angle     = theta[18:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------------

	// one sample transfer, the expectation is queued at the accepting edge
	task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y);
		while (gaps_on && $urandom_range(0, 99) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'({y, x});
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_polar.push_back(polar_of(x, y));
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------------
	// output side: checks each transfer, then picks the next ready value
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		polar_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_polar.size() == 0) begin
				report_mismatch($sformatf("output transfer with nothing pending, tdata %h",
					m_axis_tdata));
			end else begin
				want = expected_polar.pop_front();
				if (m_axis_tdata[31:0] !== want.magnitude)
					report_mismatch($sformatf("magnitude %0d, expected %0d",
						m_axis_tdata[31:0], want.magnitude));
				if (m_axis_tdata[50:32] !== want.angle)
					report_mismatch($sformatf("angle %0d, expected %0d",
						m_axis_tdata[50:32], want.angle));
			end
		end
		m_axis_tready <= gaps_on ? ($urandom_range(0, 99) >= 9) : 1'b1;
	end

	// watchdog: any transfer on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// origin, axes, diagonals, quadrant borders and full-scale corners
	task automatic test_directed();
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd32767, 16'sd0);
		send_sample(-16'sd32768, 16'sd0);
		send_sample(16'sd0, 16'sd32767);
		send_sample(16'sd0, -16'sd32768);
		send_sample(16'sd32767, 16'sd32767);
		send_sample(-16'sd32768, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(16'sd1, 16'sd0);
		send_sample(16'sd0, 16'sd1);
		send_sample(-16'sd1, 16'sd0);
		send_sample(16'sd0, -16'sd1);
		send_sample(16'sd1, 16'sd1);
		send_sample(-16'sd1, -16'sd1);
		send_sample(16'sd1, -16'sd1);
		send_sample(-16'sd1, 16'sd1);
		send_sample(16'sd5, -16'sd3);
		send_sample(-16'sd200, 16'sd700);
		// angles just above zero, just below a full turn and on either side of pi
		send_sample(16'sd32767, 16'sd1);
		send_sample(16'sd32767, -16'sd1);
		send_sample(-16'sd32768, -16'sd1);
		send_sample(-16'sd32768, 16'sd1);
	endtask

	// random vectors, weighted toward small values, axes, diagonals and full-scale corners
	task automatic test_random(input int count);
		logic signed [15:0] x, y;
		int kind;
		for (int n = 0; n < count; n++) begin
			x = 16'($urandom);
			y = 16'($urandom);
			kind = $urandom_range(0, 9);
			case (kind)
				4: begin
					x = 16'($urandom_range(0, 16) - 8);
					y = 16'($urandom_range(0, 16) - 8);
				end
				5: begin
					if ($urandom_range(0, 1))
						x = 16'($urandom_range(0, 2) - 1);
					else
						y = 16'($urandom_range(0, 2) - 1);
				end
				6: begin
					x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					if ($urandom_range(0, 1))
						y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				end
				7: begin
					y = $urandom_range(0, 1) ? x : -x;
					if ($urandom_range(0, 1))
						y = 16'(y + 1);
				end
				8, 9: begin
					x = x >>> $urandom_range(1, 14);
					y = y >>> $urandom_range(1, 14);
				end
				default: ;
			endcase
			send_sample(x, y);
		end
	endtask

	// back-to-back transfers with both sides always ready
	task automatic test_full_rate(input int count);
		gaps_on = 1'b0;
		for (int n = 0; n < count; n++)
			send_sample(16'($urandom), 16'($urandom));
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		gaps_on        = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(880);
		test_full_rate(200);
		test_random(100);

		s_axis_tvalid <= 1'b0;
		while (expected_polar.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
